// ===== sv/l2g_pkg.sv =====
package l2g_pkg;

  // Widest raster line the line store is sized for, in pixels.
  localparam int MAX_WIDTH = 2048;
  localparam int HALF_COLS = MAX_WIDTH / 2;
  localparam int COL_AW    = $clog2(HALF_COLS);
  // Block column counter can hold HALF_COLS itself (saturation point).
  localparam int BC_W      = COL_AW + 1;

  // Luma weights in Q0.16.
  localparam int W_RED   = 19589;
  localparam int W_GREEN = 38470;
  localparam int W_BLUE  = 7471;

  // Depth of the queue between the front and the back.
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = Q_AW + 1;

  localparam int RAMP_LEN = 25;
  localparam logic [RAMP_LEN*8-1:0] RAMP = "@%$#=-+*&|/}{][)('!?:;,. ";

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       line_end;
    logic       frame_start;
  } pixel_t;

  typedef struct packed {
    logic [6:0] glyph;
    logic       row_done;
  } result_t;

  // Channel sums of one horizontal pixel pair.
  typedef struct packed {
    logic [8:0] red;
    logic [8:0] green;
    logic [8:0] blue;
  } pair_t;

  localparam int PAIR_W = $bits(pair_t);

  // Averaged 2x2 block handed from the front to the back.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       row_done;
  } blk_t;

  localparam int BLK_W = $bits(blk_t);

  typedef struct packed {
    logic [Q_CW-1:0] count;
    logic            empty;
  } q_status_t;

  typedef logic [6:0] glyph_lut_t [256];

  // Gray level to ramp character, evaluated once at elaboration.
  function automatic glyph_lut_t build_glyph_lut();
    glyph_lut_t lut;
    int         percent;
    int         idx;
    for (int g = 0; g < 256; g++) begin
      percent = g * 100 / 255;
      idx     = (percent * 24 + 50) / 100;
      if (idx > RAMP_LEN - 1) begin
        idx = RAMP_LEN - 1;
      end
      lut[g] = RAMP[(RAMP_LEN - 1 - idx) * 8 +: 7];
    end
    return lut;
  endfunction

  localparam glyph_lut_t GLYPH_LUT = build_glyph_lut();

endpackage

// ===== sv/l2g_ram.sv =====
module l2g_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/l2g_front.sv =====
module l2g_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  l2g_pkg::pixel_t       pixel,
  output logic                  full,
  input  l2g_pkg::q_status_t    q_stat,
  output logic                  q_push,
  output l2g_pkg::blk_t         q_data
);
  import l2g_pkg::*;

  logic            col_phase;
  logic            row_phase;
  logic [BC_W-1:0] block_column;
  logic [7:0]      left_red;
  logic [7:0]      left_green;
  logic [7:0]      left_blue;
  logic            pend_valid;
  pair_t           pend_sums;
  logic            pend_row_done;

  logic            accept;
  logic            cp_eff;
  logic            rp_eff;
  logic [BC_W-1:0] bc_eff;
  logic            in_range;
  logic            pair_done;
  pair_t           sums;
  logic            ram_we;
  logic            ram_re;
  logic [PAIR_W-1:0] above_raw;
  pair_t           above;
  logic [9:0]      tot_red;
  logic [9:0]      tot_green;
  logic [9:0]      tot_blue;

  // Worst case the queue must still absorb the block in the pending stage
  // plus one more, so hold off while that room is not there.
  assign full = (q_stat.count + Q_CW'(pend_valid)) >= Q_CW'(Q_DEPTH - 1);

  assign accept    = push && !full;
  assign cp_eff    = pixel.frame_start ? 1'b0 : col_phase;
  assign rp_eff    = pixel.frame_start ? 1'b0 : row_phase;
  assign bc_eff    = pixel.frame_start ? '0 : block_column;
  assign in_range  = bc_eff < BC_W'(HALF_COLS);
  assign pair_done = accept && cp_eff;

  assign sums.red   = {1'b0, left_red}   + {1'b0, pixel.red};
  assign sums.green = {1'b0, left_green} + {1'b0, pixel.green};
  assign sums.blue  = {1'b0, left_blue}  + {1'b0, pixel.blue};

  assign ram_we = pair_done && in_range && !rp_eff;
  assign ram_re = pair_done && in_range && rp_eff;

  l2g_ram #(
    .WIDTH (PAIR_W),
    .DEPTH (HALF_COLS)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (bc_eff[COL_AW-1:0]),
    .wdata (sums),
    .re    (ram_re),
    .raddr (bc_eff[COL_AW-1:0]),
    .rdata (above_raw)
  );

  assign above = pair_t'(above_raw);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_phase    <= 1'b0;
      row_phase    <= 1'b0;
      block_column <= '0;
      pend_valid   <= 1'b0;
    end else begin
      pend_valid <= ram_re;
      if (accept) begin
        col_phase <= pixel.line_end ? 1'b0 : !cp_eff;
        row_phase <= rp_eff ^ pixel.line_end;
        if (pixel.line_end) begin
          block_column <= '0;
        end else if (cp_eff && in_range) begin
          block_column <= bc_eff + BC_W'(1);
        end else begin
          block_column <= bc_eff;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !cp_eff) begin
      left_red   <= pixel.red;
      left_green <= pixel.green;
      left_blue  <= pixel.blue;
    end
    if (ram_re) begin
      pend_sums     <= sums;
      pend_row_done <= pixel.line_end;
    end
  end

  // Add the stored upper pair to the lower pair and divide by four.
  assign tot_red   = {1'b0, pend_sums.red}   + {1'b0, above.red};
  assign tot_green = {1'b0, pend_sums.green} + {1'b0, above.green};
  assign tot_blue  = {1'b0, pend_sums.blue}  + {1'b0, above.blue};

  assign q_push          = pend_valid;
  assign q_data.red      = tot_red[9:2];
  assign q_data.green    = tot_green[9:2];
  assign q_data.blue     = tot_blue[9:2];
  assign q_data.row_done = pend_row_done;

  a_ram_one_port: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("line store written and read in the same cycle");

  a_pend_room: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (q_stat.count != Q_CW'(Q_DEPTH)))
    else $error("pending block has no room in the queue");

endmodule

// ===== sv/l2g_fifo.sv =====
module l2g_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  l2g_pkg::blk_t      wdata,
  input  logic               pop,
  output l2g_pkg::blk_t      rdata,
  output l2g_pkg::q_status_t stat
);
  import l2g_pkg::*;

  blk_t            mem [Q_DEPTH];
  logic [Q_AW-1:0] wptr;
  logic [Q_AW-1:0] rptr;
  logic [Q_CW-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == Q_AW'(Q_DEPTH - 1)) ? '0 : wptr + Q_AW'(1);
      end
      if (pop) begin
        rptr <= (rptr == Q_AW'(Q_DEPTH - 1)) ? '0 : rptr + Q_AW'(1);
      end
      if (push && !pop) begin
        count <= count + Q_CW'(1);
      end else if (pop && !push) begin
        count <= count - Q_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  assign rdata      = mem[rptr];
  assign stat.count = count;
  assign stat.empty = (count == '0);

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != Q_CW'(Q_DEPTH)) || pop)
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("queue underflow");

endmodule

// ===== sv/l2g_back.sv =====
module l2g_back (
  input  logic                  clk,
  input  logic                  rst,
  input  l2g_pkg::q_status_t    q_stat,
  input  l2g_pkg::blk_t         q_data,
  output logic                  q_pop,
  output logic                  empty,
  input  logic                  pop,
  output l2g_pkg::result_t      result
);
  import l2g_pkg::*;

  logic        s1_valid;
  logic [22:0] prod_red;
  logic [23:0] prod_green;
  logic [20:0] prod_blue;
  logic        s1_row_done;
  logic        s2_valid;
  result_t     s2_data;

  logic        s2_ready;
  logic        s1_adv;
  logic [23:0] luma;

  assign s2_ready = !s2_valid || pop;
  assign s1_adv   = !s1_valid || s2_ready;
  assign q_pop    = !q_stat.empty && s1_adv;

  // Sum of the three weighted channels stays below 2^24.
  assign luma = {1'b0, prod_red} + prod_green + {3'b000, prod_blue};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid <= !q_stat.empty;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      prod_red    <= 23'(q_data.red   * 15'(W_RED));
      prod_green  <= 24'(q_data.green * 16'(W_GREEN));
      prod_blue   <= 21'(q_data.blue  * 13'(W_BLUE));
      s1_row_done <= q_data.row_done;
    end
    if (s2_ready && s1_valid) begin
      s2_data.glyph    <= GLYPH_LUT[luma[23:16]];
      s2_data.row_done <= s1_row_done;
    end
  end

  assign empty  = !s2_valid;
  assign result = s2_data;

endmodule

// ===== sv/block_luma_to_ascii_glyph.sv =====
// Channel   Direction  Handshake            Payload
// pixel     in         push / full          red, green, blue, line_end, frame_start
// result    out        empty / pop          glyph, row_done
//
// One pixel request is taken per clock while full is low; full depends on
// registers only. The pixel that completes a 2x2 block sends its glyph
// through the line store read, the queue write, the weighting stage and
// the glyph lookup into the output register, in that order. Reset
// (rst, synchronous) clears the row and column phase, the block column and
// all pipeline valids; the line store needs no clearing pass. While a
// result waits unpopped, the output register and the weighting stage hold,
// the queue keeps taking blocks, and full rises once the queued blocks plus
// the one in the line store read stage reach three.
module block_luma_to_ascii_glyph (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  l2g_pkg::pixel_t   pixel,
  output logic              full,
  output logic              empty,
  input  logic              pop,
  output l2g_pkg::result_t  result
);
  import l2g_pkg::*;

  // The front tracks the pair and row phase of the raster, sums horizontal
  // pairs, parks the pair sums of the upper row in the line store and, on
  // the lower row, reads them back to form the 2x2 average.
  q_status_t q_stat;
  logic      q_push;
  logic      q_pop;
  blk_t      q_wdata;
  blk_t      q_rdata;

  l2g_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .pixel  (pixel),
    .full   (full),
    .q_stat (q_stat),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  // A short queue of averaged blocks lets the front run on while the
  // consumer of the glyphs is stalled.
  l2g_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  // The back weights the channels into Q8.16 luma in one stage, then maps
  // the gray level to its ramp character through a constant table into the
  // output register.
  l2g_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_stat (q_stat),
    .q_data (q_rdata),
    .q_pop  (q_pop),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

endmodule

// ===== tb/sv/glyph_ledger_pkg.sv =====
package glyph_ledger_pkg;

  import l2g_pkg::*;

  // Luma weights in Q0.16 and the steps from gray level to ramp position.
  localparam int LUMA_RED    = 19589;
  localparam int LUMA_GREEN  = 38470;
  localparam int LUMA_BLUE   = 7471;
  localparam int LUMA_SHIFT  = 16;
  localparam int PERCENT_TOP = 100;
  localparam int GRAY_TOP    = 255;
  localparam int RAMP_LAST   = 24;

  // Pixel pairs per line that the line store keeps.
  localparam int ROW_PAIRS = 1024;

  typedef struct packed {
    logic [8:0] red;
    logic [8:0] green;
    logic [8:0] blue;
  } duo_sum_t;

  // Tracks the glyphs the block owes: every accepted pixel request is folded
  // into a private copy of the block state, and each finished 2x2 block
  // leaves one expected glyph behind.
  class glyph_ledger;

    string    ramp_chars = "@%$#=-+*&|/}{][)('!?:;,. ";
    bit       pair_open;
    bit       second_row;
    int       block_col;
    duo_sum_t pair_now;
    duo_sum_t upper_row [ROW_PAIRS];
    result_t  owed_glyphs [$];
    int       errors;

    function int pending();
      return owed_glyphs.size();
    endfunction

    function logic [6:0] glyph_for(int r, int g, int b);
      int  gray;
      int  percent;
      int  idx;
      byte c;
      gray    = (LUMA_RED * r + LUMA_GREEN * g + LUMA_BLUE * b) >> LUMA_SHIFT;
      percent = gray * PERCENT_TOP / GRAY_TOP;
      idx     = (percent * RAMP_LAST + PERCENT_TOP / 2) / PERCENT_TOP;
      if (idx > RAMP_LAST) begin
        idx = RAMP_LAST;
      end
      c = ramp_chars.getc(idx);
      return c[6:0];
    endfunction

    function void take_pixel(pixel_t p);
      duo_sum_t above;
      result_t  owed;
      if (p.frame_start) begin
        pair_open  = 1'b0;
        second_row = 1'b0;
        block_col  = 0;
      end
      if (!pair_open) begin
        pair_now  = '{{1'b0, p.red}, {1'b0, p.green}, {1'b0, p.blue}};
        pair_open = 1'b1;
      end else begin
        pair_now.red   = pair_now.red + p.red;
        pair_now.green = pair_now.green + p.green;
        pair_now.blue  = pair_now.blue + p.blue;
        pair_open      = 1'b0;
        // Pairs past the end of the line store are simply lost.
        if (block_col < ROW_PAIRS) begin
          if (!second_row) begin
            upper_row[block_col] = pair_now;
          end else begin
            above         = upper_row[block_col];
            owed.glyph    = glyph_for((int'(pair_now.red) + int'(above.red)) >> 2,
                                      (int'(pair_now.green) + int'(above.green)) >> 2,
                                      (int'(pair_now.blue) + int'(above.blue)) >> 2);
            owed.row_done = p.line_end;
            owed_glyphs.push_back(owed);
          end
          block_col++;
        end
      end
      if (p.line_end) begin
        pair_open  = 1'b0;
        block_col  = 0;
        second_row = !second_row;
      end
    endfunction

    function void check_glyph(result_t got);
      result_t want;
      if (owed_glyphs.size() == 0) begin
        $error("glyph %0d arrived with none outstanding", got.glyph);
        errors++;
        return;
      end
      want = owed_glyphs.pop_front();
      if (got.glyph !== want.glyph) begin
        $error("glyph: expected %0d, got %0d", want.glyph, got.glyph);
        errors++;
      end
      if (got.row_done !== want.row_done) begin
        $error("row_done: expected %0d, got %0d", want.row_done, got.row_done);
        errors++;
      end
    endfunction

  endclass

endpackage

// ===== tb/sv/testbench.sv =====
module testbench;

  import l2g_pkg::*;
  import glyph_ledger_pkg::*;

  // Simulation stops here no matter what; the slowest legal run is several
  // times shorter than this.
  localparam int LIMIT_TIME    = 5_000_000;
  localparam int RESET_CYCLES  = 8;
  localparam int MAX_GAP       = 13;
  localparam int RANDOM_PIXELS = 800;
  // The receiver stops popping for this long at a couple of points so that
  // the result queue fills and full has to rise.
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_AT_FIRST = 40;
  localparam int HOLD_AT_LAST  = 120;
  // Pipeline latency plus the result queue, with some margin.
  localparam int DRAIN_CYCLES  = 16;

  logic    clk   = 1'b0;
  logic    rst   = 1'b1;
  logic    push  = 1'b0;
  pixel_t  pixel = '0;
  logic    full;
  logic    empty;
  logic    pop   = 1'b0;
  result_t result;

  glyph_ledger ledger = new;

  // Shadow of the block's line position, kept on the stimulus side. The
  // generator uses it to make sure a second row never reads a line store
  // entry that no first row has written since reset.
  bit gen_pair_open;
  bit gen_second_row;
  int gen_block_col;
  int gen_stored_cols;

  // Each side switches between a calm mode (back to back) and a mode with
  // random gaps, so both long busy stretches and gaps at every phase occur.
  bit send_calm;
  bit take_calm;

  always #5 clk = ~clk;

  block_luma_to_ascii_glyph uut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .pixel  (pixel),
    .full   (full),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  // Advances the shadow position over one pixel. If the pixel would complete
  // a second-row pair over an unwritten store entry, it is turned into a
  // frame start instead, which restarts the frame on a first row.
  function automatic pixel_t plan_pixel(pixel_t p);
    pixel_t q;
    q = p;
    if (q.frame_start) begin
      gen_pair_open  = 1'b0;
      gen_second_row = 1'b0;
      gen_block_col  = 0;
    end
    if (gen_pair_open && gen_second_row && gen_block_col < ROW_PAIRS &&
        gen_block_col >= gen_stored_cols) begin
      q.frame_start  = 1'b1;
      gen_pair_open  = 1'b0;
      gen_second_row = 1'b0;
      gen_block_col  = 0;
    end
    if (!gen_pair_open) begin
      gen_pair_open = 1'b1;
    end else begin
      gen_pair_open = 1'b0;
      if (gen_block_col < ROW_PAIRS) begin
        if (!gen_second_row && gen_block_col >= gen_stored_cols) begin
          gen_stored_cols = gen_block_col + 1;
        end
        gen_block_col++;
      end
    end
    if (q.line_end) begin
      gen_pair_open  = 1'b0;
      gen_block_col  = 0;
      gen_second_row = !gen_second_row;
    end
    return q;
  endfunction

  // A tone of zero or more gives a near-flat level around it so that every
  // part of the ramp gets hit; otherwise levels are random with the two
  // extremes favored.
  function automatic logic [7:0] pick_level(int tone);
    if (tone >= 0) begin
      return 8'(tone) ^ 8'($urandom_range(0, 7));
    end
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Offers one pixel request and returns at the edge that accepts it. Push
  // stays high when the next request follows with no gap, so it is never
  // lowered and raised in the same time step.
  task automatic send_pixel(pixel_t want);
    pixel_t p;
    int     gap;
    p = plan_pixel(want);
    if ($urandom_range(0, 31) == 0) begin
      send_calm = !send_calm;
    end
    gap = send_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push  <= 1'b1;
    pixel <= p;
    @(posedge clk);
    while (full) @(posedge clk);
    ledger.take_pixel(p);
  endtask

  task automatic send_rgb(logic [7:0] r, logic [7:0] g, logic [7:0] b, bit eol, bit sof);
    pixel_t p;
    p.red         = r;
    p.green       = g;
    p.blue        = b;
    p.line_end    = eol;
    p.frame_start = sof;
    send_pixel(p);
  endtask

  // Sends one raster line. With noisy set, a stray frame start may land in
  // the middle of the line and break the block row apart.
  task automatic send_line(int len, bit fresh, int tone, bit noisy);
    pixel_t p;
    for (int k = 0; k < len; k++) begin
      p.red         = pick_level(tone);
      p.green       = pick_level(tone);
      p.blue        = pick_level(tone);
      p.line_end    = (k == len - 1);
      p.frame_start = (k == 0 && fresh) || (noisy && $urandom_range(0, 59) == 0);
      send_pixel(p);
    end
  endtask

  // Accepts one result request and checks it. The result fields are read
  // right after the accepting edge, so they still hold the values that the
  // edge saw.
  task automatic take_glyph();
    int gap;
    if ($urandom_range(0, 31) == 0) begin
      take_calm = !take_calm;
    end
    gap = take_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      pop <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pop <= 1'b1;
    @(posedge clk);
    while (empty) @(posedge clk);
    ledger.check_glyph(result);
  endtask

  // Receiving side: runs for the whole test and holds off twice for a long
  // stretch while the sender keeps pushing.
  initial begin
    int taken;
    taken = 0;
    while (rst) @(posedge clk);
    forever begin
      if (taken == HOLD_AT_FIRST || taken == HOLD_AT_LAST) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      take_glyph();
      taken++;
    end
  end

  // Sending side and the end of the test.
  initial begin
    int sent;
    int row_len;
    int tone;
    bit fresh;
    sent    = 0;
    row_len = 8;
    tone    = -1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed frame: black, white and primary colors over two rows, so both
    // ends of the ramp show up and the last glyph carries row_done.
    send_rgb(8'd0, 8'd0, 8'd0, 1'b0, 1'b1);
    send_rgb(8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
    send_rgb(8'd255, 8'd255, 8'd255, 1'b0, 1'b0);
    send_rgb(8'd255, 8'd255, 8'd255, 1'b0, 1'b0);
    send_rgb(8'd255, 8'd0, 8'd0, 1'b0, 1'b0);
    send_rgb(8'd0, 8'd255, 8'd0, 1'b1, 1'b0);
    send_rgb(8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
    send_rgb(8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
    send_rgb(8'd255, 8'd255, 8'd255, 1'b0, 1'b0);
    send_rgb(8'd255, 8'd255, 8'd255, 1'b0, 1'b0);
    send_rgb(8'd0, 8'd0, 8'd255, 1'b0, 1'b0);
    send_rgb(8'd128, 8'd64, 8'd200, 1'b1, 1'b0);
    // Lines of odd length: the trailing pixel is dropped, and the glyph that
    // came just before it carries no row_done.
    send_rgb(8'd10, 8'd20, 8'd30, 1'b0, 1'b0);
    send_rgb(8'd200, 8'd100, 8'd50, 1'b0, 1'b0);
    send_rgb(8'd77, 8'd77, 8'd77, 1'b1, 1'b0);
    send_rgb(8'd1, 8'd2, 8'd3, 1'b0, 1'b0);
    send_rgb(8'd250, 8'd240, 8'd230, 1'b0, 1'b0);
    send_rgb(8'd9, 8'd9, 8'd9, 1'b1, 1'b0);
    // A first row followed by a new frame gives nothing; the new frame's
    // block row then completes as usual.
    send_rgb(8'd60, 8'd60, 8'd60, 1'b0, 1'b0);
    send_rgb(8'd90, 8'd90, 8'd90, 1'b1, 1'b0);
    send_rgb(8'd15, 8'd170, 8'd15, 1'b0, 1'b1);
    send_rgb(8'd240, 8'd30, 8'd99, 1'b1, 1'b0);
    send_rgb(8'd127, 8'd128, 8'd129, 1'b0, 1'b0);
    send_rgb(8'd33, 8'd222, 8'd254, 1'b1, 1'b0);

    // Random raster: mostly well-formed block rows of short even lines,
    // with odd lengths, mismatched second rows and stray frame starts mixed
    // in.
    while (sent < RANDOM_PIXELS) begin
      if (!gen_second_row) begin
        row_len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 25)
                                              : 2 * $urandom_range(1, 12);
        tone    = $urandom_range(0, 1) ? $urandom_range(0, 255) : -1;
        fresh   = ($urandom_range(0, 3) == 0);
      end else begin
        if ($urandom_range(0, 5) == 0) begin
          row_len = $urandom_range(1, 25);
        end
        fresh = ($urandom_range(0, 15) == 0);
      end
      send_line(row_len, fresh, tone, 1'b1);
      sent += row_len;
    end

    push <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (ledger.errors == 0) begin
      $display("[block_luma_to_ascii_glyph] OK");
    end else begin
      $display("[block_luma_to_ascii_glyph] ERROR");
    end
    $finish;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  initial begin
    #LIMIT_TIME;
    $display("[block_luma_to_ascii_glyph] ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/l2g_pkg.sv
sv/l2g_ram.sv
sv/l2g_front.sv
sv/l2g_fifo.sv
sv/l2g_back.sv
sv/block_luma_to_ascii_glyph.sv
tb/sv/glyph_ledger_pkg.sv
tb/sv/testbench.sv
